FILE: rtl/core/mwlfo_pkg.sv
// ----------------------------------------------------------------------------
// mwlfo_pkg
// Shared types, register codes and the quarter-wave sine table function for
// the multi-waveform phase-accumulator LFO.
// ----------------------------------------------------------------------------
package mwlfo_pkg;

  localparam int CHANNELS_DEF       = 2;
  localparam int SINE_ADDR_BITS_DEF = 10;

  localparam int PHASE_W  = 32;
  localparam int INC_W    = 31;
  localparam int DEPTH_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int ROM_W    = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'h8000;

  typedef enum logic [1:0] {
    WAVE_SINE     = 2'd0,
    WAVE_SQUARE   = 2'd1,
    WAVE_TRIANGLE = 2'd2,
    WAVE_SAW      = 2'd3
  } wave_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 2'd0,
    CFG_WAVEFORM  = 2'd1,
    CFG_DEPTH     = 2'd2
  } cfg_idx_t;

  // Q30 Taylor coefficients of sin(pi/2 * t)
  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598669;
  localparam longint unsigned SIN_C5 = 64'd85569306;
  localparam longint unsigned SIN_C7 = 64'd5026995;
  localparam longint unsigned SIN_C9 = 64'd172272;

  // Quarter-wave entry k, unsigned Q15, clamped to 1.0. Elaboration only.
  function automatic logic [ROM_W-1:0] quarter_rom(input int k, input int addr_bits);
    longint unsigned t;
    longint unsigned u;
    longint unsigned p;
    longint unsigned s;
    t = 64'(k) << (30 - addr_bits);
    u = (t * t) >> 30;
    p = SIN_C9;
    p = SIN_C7 - ((p * u) >> 30);
    p = SIN_C5 - ((p * u) >> 30);
    p = SIN_C3 - ((p * u) >> 30);
    p = SIN_C1 - ((p * u) >> 30);
    s = (p * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return ROM_W'(s);
  endfunction

endpackage

FILE: rtl/core/mwlfo_sine_rom.sv
// ----------------------------------------------------------------------------
// mwlfo_sine_rom
// Quarter-wave sine table, 2^ADDR_BITS + 1 entries, registered read.
// ----------------------------------------------------------------------------
module mwlfo_sine_rom #(
  parameter int ADDR_BITS = mwlfo_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ADDR_BITS:0]            rd_addr,
  output logic [mwlfo_pkg::ROM_W-1:0]   rd_data
);

  localparam int ENTRIES = (1 << ADDR_BITS) + 1;

  logic [mwlfo_pkg::ROM_W-1:0] rom_tbl [ENTRIES];
  logic [mwlfo_pkg::ROM_W-1:0] rd_data_r;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
    assign rom_tbl[k] = mwlfo_pkg::quarter_rom(k, ADDR_BITS);
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= rom_tbl[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/multi_waveform_lfo.sv
// ----------------------------------------------------------------------------
// multi_waveform_lfo
// Per-channel phase accumulator LFO with sine, square, triangle and saw
// outputs in signed Q1.15.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  in_       in         in_valid/in_stall  in_channel
//  out_      out        out_valid/out_stall out_sample
//  cfg_      in         cfg_we             cfg_index, cfg_wdata
//
// One word accepted per cycle while in_stall is low. The stages are phase add,
// table read, and depth multiply and saturate; the sine table read is registered.
// The three stages close bubbles independently, so input is taken while a
// result waits as long as a stage is free.
// Synchronous active-low reset clears phases, configuration registers and stage valids.
// ----------------------------------------------------------------------------
module multi_waveform_lfo #(
  parameter int CHANNELS       = mwlfo_pkg::CHANNELS_DEF,
  parameter int SINE_ADDR_BITS = mwlfo_pkg::SINE_ADDR_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_channel,

  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [mwlfo_pkg::SAMPLE_W-1:0] out_sample,

  input  logic                                  cfg_we,
  input  logic [mwlfo_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mwlfo_pkg::INC_W-1:0]           cfg_wdata
);

  localparam int PW  = mwlfo_pkg::PHASE_W;
  localparam int SW  = mwlfo_pkg::SAMPLE_W;
  localparam int RW  = mwlfo_pkg::ROM_W;
  localparam int DW  = mwlfo_pkg::DEPTH_W;
  localparam int RAW = SINE_ADDR_BITS + 1;

  // configuration
  logic [mwlfo_pkg::INC_W-1:0] phase_inc_r;
  mwlfo_pkg::wave_t            waveform_r;
  logic [DW-1:0]               depth_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_inc_r <= '0;
      waveform_r  <= mwlfo_pkg::WAVE_SINE;
      depth_r     <= mwlfo_pkg::DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (mwlfo_pkg::cfg_idx_t'(cfg_index))
        mwlfo_pkg::CFG_PHASE_INC: phase_inc_r <= cfg_wdata;
        mwlfo_pkg::CFG_WAVEFORM:  waveform_r  <= mwlfo_pkg::wave_t'(cfg_wdata[1:0]);
        mwlfo_pkg::CFG_DEPTH:     depth_r     <= cfg_wdata[DW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic out_free, s2_free, s1_free, in_acc;

  assign out_free = !out_valid_r || !out_stall;
  assign s2_free  = !s2_valid_r || out_free;
  assign s1_free  = !s1_valid_r || s2_free;
  assign in_stall = !s1_free;
  assign in_acc   = in_valid && s1_free;

  // phase accumulators
  logic [PW-1:0] phase_r [CHANNELS];
  logic [PW-1:0] phase_cur;
  logic [PW-1:0] phase_nxt;
  logic          in_hit;

  assign in_hit = (32'(in_channel) < 32'(CHANNELS));

  always_comb begin
    phase_cur = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (32'(in_channel) == 32'(i)) begin
        phase_cur = phase_r[i];
      end
    end
  end

  assign phase_nxt = phase_cur + {1'b0, phase_inc_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        phase_r[i] <= '0;
      end
    end else if (in_acc && in_hit) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (32'(in_channel) == 32'(i)) begin
          phase_r[i] <= phase_nxt;
        end
      end
    end
  end

  // stage 1: wrapped phase
  logic [PW-1:0] s1_phase_r;
  logic          s1_hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_phase_r <= phase_nxt;
      s1_hit_r   <= in_hit;
    end
  end

  // stage 1 -> 2: table address and the non-sine shapes
  logic [1:0]                quad;
  logic [SINE_ADDR_BITS-1:0] quad_addr;
  logic [RAW-1:0]            rom_addr;
  logic [16:0]               q17;
  logic [15:0]               tri_mid;
  logic signed [SW-1:0]      shape_val;
  logic                      s1_load;
  logic [RW-1:0]             rom_q;

  assign quad      = s1_phase_r[PW-1 -: 2];
  assign quad_addr = s1_phase_r[PW-3 -: SINE_ADDR_BITS];
  assign rom_addr  = quad[0] ? ({1'b1, {SINE_ADDR_BITS{1'b0}}} - {1'b0, quad_addr})
                             : {1'b0, quad_addr};
  assign q17       = s1_phase_r[PW-1:15];
  assign tri_mid   = 16'd0 - q17[15:0];
  assign s1_load   = s1_valid_r && s2_free;

  always_comb begin
    shape_val = '0;
    case (waveform_r)
      mwlfo_pkg::WAVE_SQUARE: begin
        shape_val = (s1_phase_r <= 32'h8000_0000) ? 16'sh7fff : 16'sh8000;
      end
      mwlfo_pkg::WAVE_TRIANGLE: begin
        if (quad == 2'b00 || quad == 2'b11) begin
          shape_val = q17[15:0];
        end else if (q17 == 17'd32768) begin
          shape_val = 16'sh7fff;
        end else begin
          shape_val = tri_mid;
        end
      end
      mwlfo_pkg::WAVE_SAW: begin
        shape_val = {~s1_phase_r[30], s1_phase_r[29:15]};
      end
      default: shape_val = '0;
    endcase
  end

  mwlfo_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_sine_rom (
    .clk     (clk),
    .rd_en   (s1_load),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // stage 2
  logic                 s2_hit_r;
  logic                 s2_sine_r;
  logic                 s2_neg_r;
  logic signed [SW-1:0] s2_shape_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s2_hit_r   <= s1_hit_r;
      s2_sine_r  <= (waveform_r == mwlfo_pkg::WAVE_SINE);
      s2_neg_r   <= quad[1];
      s2_shape_r <= shape_val;
    end
  end

  // stage 2 -> out: scale sine by depth, round, sign, saturate
  logic [RW+DW-1:0]     prod;
  logic [RW+DW:0]       prod_rnd;
  logic [17:0]          mag;
  logic signed [SW-1:0] sine_val;
  logic signed [SW-1:0] sample_nxt;
  logic signed [SW-1:0] out_sample_r;

  assign prod     = rom_q * depth_r;
  assign prod_rnd = {1'b0, prod} + 33'd16384;
  assign mag      = prod_rnd[RW+DW:15];

  always_comb begin
    if (!s2_neg_r) begin
      sine_val = (mag > 18'd32767) ? 16'sh7fff : mag[15:0];
    end else begin
      sine_val = (mag >= 18'd32768) ? 16'sh8000 : (16'd0 - mag[15:0]);
    end
  end

  always_comb begin
    if (!s2_hit_r) begin
      sample_nxt = '0;
    end else if (s2_sine_r) begin
      sample_nxt = sine_val;
    end else begin
      sample_nxt = s2_shape_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  // hold the word while stalled
  always_ff @(posedge clk) begin
    if (out_free && s2_valid_r) begin
      out_sample_r <= sample_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule
